// ----- rtl/dflp_pkg.sv -----
// Package: shared constants, types and the character classifier of the literal parser.
`default_nettype none
package dflp_pkg;

   localparam int MANTISSA_BITS = 64;
   localparam int MANT_OUT_W    = 64;
   localparam int EXP_ACC_W     = 16;
   localparam int EXP_OUT_W     = 17;

   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_E_UPPER    = 8'h45;
   localparam logic [7:0] CHAR_E_LOWER    = 8'h65;
   localparam logic [7:0] CHAR_L_UPPER    = 8'h4C;
   localparam logic [7:0] CHAR_L_LOWER    = 8'h6C;

   typedef enum logic [2:0] {
      CL_DIGIT,
      CL_PLUS,
      CL_MINUS,
      CL_UNDERSCORE,
      CL_DOT,
      CL_EXP,
      CL_LONG,
      CL_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_INT,
      PH_FRAC_NEW,
      PH_FRAC,
      PH_EXP_START,
      PH_EXP,
      PH_LONG
   } phase_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           is_last;
   } token_type;

   function automatic token_type classify(input logic [7:0] code, input logic last);
      token_type tok;
      tok.is_last = last;
      tok.digit   = 4'd0;
      if (code inside {[CHAR_ZERO:CHAR_NINE]}) begin
         tok.cls   = CL_DIGIT;
         tok.digit = 4'(code - CHAR_ZERO);
      end else if (code == CHAR_PLUS) begin
         tok.cls = CL_PLUS;
      end else if (code == CHAR_MINUS) begin
         tok.cls = CL_MINUS;
      end else if (code == CHAR_UNDERSCORE) begin
         tok.cls = CL_UNDERSCORE;
      end else if (code == CHAR_DOT) begin
         tok.cls = CL_DOT;
      end else if (code inside {CHAR_E_UPPER, CHAR_E_LOWER}) begin
         tok.cls = CL_EXP;
      end else if (code inside {CHAR_L_UPPER, CHAR_L_LOWER}) begin
         tok.cls = CL_LONG;
      end else begin
         tok.cls = CL_OTHER;
      end
      return tok;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/dflp_if.sv -----
// Interfaces: request (character) and response (parsed literal) channels.
`default_nettype none
interface dflp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface dflp_rsp_if;
   logic        valid;
   logic        ready;
   logic        negative;
   logic [63:0] mantissa;
   logic signed [16:0] exponent;
   logic        long_literal;
   logic        parse_error;
   logic        mantissa_wrapped;

   modport source (output valid, output negative, output mantissa, output exponent,
                   output long_literal, output parse_error, output mantissa_wrapped,
                   input ready);
   modport sink   (input valid, input negative, input mantissa, input exponent,
                   input long_literal, input parse_error, input mantissa_wrapped,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/dflp_front.sv -----
// Front end: accepts characters and registers their classified token.
`default_nettype none
module dflp_front
   import dflp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   dflp_req_if.sink       req_chan,
   output token_type      tok_out,
   output logic           tok_valid,
   input  wire logic      tok_ready
);

   token_type tok_ff, tok_in;
   logic      valid_ff, valid_in;
   logic      take;

   assign req_chan.ready = !valid_ff || tok_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      tok_in   = tok_ff;
      valid_in = valid_ff;
      if (take) begin
         tok_in   = classify(req_chan.char_code, req_chan.is_last);
         valid_in = 1'b1;
      end else if (tok_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tok_ff <= tok_in;
   end

   assign tok_out   = tok_ff;
   assign tok_valid = valid_ff;

endmodule
`default_nettype wire

// ----- rtl/dflp_queue.sv -----
// Two-entry token queue between front end and parser back end.
`default_nettype none
module dflp_queue
   import dflp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type push_tok,
   input  wire logic      push_valid,
   output logic           push_ready,
   output token_type      pop_tok,
   output logic           pop_valid,
   input  wire logic      pop_ready
);

   token_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tok    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dflp_back.sv -----
// Back end: grammar state machine, digit accumulation and response register.
`default_nettype none
module dflp_back
   import dflp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type tok,
   input  wire logic      tok_valid,
   output logic           tok_ready,
   dflp_rsp_if.source     rsp_chan
);

   localparam int PROD_W = MANTISSA_BITS + 4;

   phase_type                 phase_ff, phase_in, eff_phase;
   logic                      sign_ff, sign_in;
   logic [MANTISSA_BITS-1:0]  mant_ff, mant_in;
   logic [EXP_ACC_W-1:0]      frac_ff, frac_in;
   logic [EXP_ACC_W-1:0]      eacc_ff, eacc_in;
   logic                      eneg_ff, eneg_in;
   logic                      have_ff, have_in;
   logic                      upend_ff, upend_in;
   logic                      failed_ff, failed_in;
   logic                      wrap_ff, wrap_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_neg_ff;
   logic [MANT_OUT_W-1:0]     out_mant_ff;
   logic signed [EXP_OUT_W-1:0] out_exp_ff;
   logic                      out_long_ff, out_err_ff, out_wrap_ff;

   logic                      out_free, step, finish;
   logic                      is_dig, active, sign_start, go;
   logic [PROD_W-1:0]         mant_prod;
   logic                      mant_over;
   logic [EXP_ACC_W-1:0]      eacc_prod;
   logic [EXP_ACC_W-1:0]      frac_term, exp_term;
   logic signed [EXP_OUT_W-1:0] total;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign tok_ready = !tok.is_last || out_free;
   assign step      = tok_valid && tok_ready;
   assign finish    = step && tok.is_last;

   assign is_dig     = (tok.cls == CL_DIGIT);
   // a pending underscore must be followed by a digit
   assign active     = step && !failed_ff && !(upend_ff && !is_dig);
   assign sign_start = active && (phase_ff == PH_START)
                       && (tok.cls == CL_PLUS || tok.cls == CL_MINUS);
   assign go         = active && !sign_start;
   assign eff_phase  = (phase_ff == PH_START) ? PH_INT : phase_ff;

   // mantissa*10 + digit with the carry-out bits showing a wrap
   assign mant_prod = {1'b0, mant_ff, 3'b000} + {3'b000, mant_ff, 1'b0}
                      + {{(PROD_W-4){1'b0}}, tok.digit};
   assign mant_over = |mant_prod[PROD_W-1:MANTISSA_BITS];
   assign eacc_prod = {eacc_ff[EXP_ACC_W-4:0], 3'b000} + {eacc_ff[EXP_ACC_W-2:0], 1'b0}
                      + {{(EXP_ACC_W-4){1'b0}}, tok.digit};

   // next grammar phase
   always_comb begin
      phase_in = phase_ff;
      if (sign_start) begin
         phase_in = PH_INT;
      end else if (go) begin
         phase_in = eff_phase;
         case (eff_phase)
            PH_INT: begin
               if (tok.cls == CL_LONG) begin
                  phase_in = PH_LONG;
               end else if (tok.cls == CL_DOT) begin
                  phase_in = PH_FRAC_NEW;
               end else if (tok.cls == CL_EXP && have_ff) begin
                  phase_in = PH_EXP_START;
               end
            end
            PH_FRAC_NEW, PH_FRAC: begin
               if (is_dig) begin
                  phase_in = PH_FRAC;
               end else if (tok.cls == CL_EXP && have_ff) begin
                  phase_in = PH_EXP_START;
               end
            end
            PH_EXP_START, PH_EXP: begin
               if (is_dig) begin
                  phase_in = PH_EXP;
               end else if (eff_phase == PH_EXP_START
                            && (tok.cls == CL_PLUS || tok.cls == CL_MINUS)) begin
                  phase_in = PH_EXP;
               end
            end
            default: begin
               phase_in = eff_phase;
            end
         endcase
      end
   end

   // accumulators and flags
   always_comb begin
      sign_in   = sign_ff;
      mant_in   = mant_ff;
      frac_in   = frac_ff;
      eacc_in   = eacc_ff;
      eneg_in   = eneg_ff;
      have_in   = have_ff;
      upend_in  = upend_ff;
      failed_in = failed_ff;
      wrap_in   = wrap_ff;
      if (step && !failed_ff && upend_ff && !is_dig) begin
         failed_in = 1'b1;
      end
      if (active) begin
         upend_in = 1'b0;
      end
      if (sign_start) begin
         sign_in = (tok.cls == CL_MINUS);
      end else if (go) begin
         case (eff_phase)
            PH_INT: begin
               if (is_dig) begin
                  mant_in = mant_prod[MANTISSA_BITS-1:0];
                  wrap_in = wrap_ff || mant_over;
                  have_in = 1'b1;
               end else if (tok.cls == CL_UNDERSCORE && have_ff) begin
                  upend_in = 1'b1;
               end else if (tok.cls == CL_LONG || tok.cls == CL_DOT) begin
                  have_in = have_ff;
               end else if (tok.cls == CL_EXP && have_ff) begin
                  have_in = 1'b0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_FRAC_NEW, PH_FRAC: begin
               if (is_dig) begin
                  mant_in = mant_prod[MANTISSA_BITS-1:0];
                  wrap_in = wrap_ff || mant_over;
                  have_in = 1'b1;
                  frac_in = frac_ff + EXP_ACC_W'(1);
               end else if (tok.cls == CL_UNDERSCORE && eff_phase == PH_FRAC) begin
                  upend_in = 1'b1;
               end else if (tok.cls == CL_EXP && have_ff) begin
                  have_in = 1'b0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_EXP_START, PH_EXP: begin
               if (is_dig) begin
                  eacc_in = eacc_prod;
                  have_in = 1'b1;
               end else if (eff_phase == PH_EXP_START
                            && (tok.cls == CL_PLUS || tok.cls == CL_MINUS)) begin
                  eneg_in = (tok.cls == CL_MINUS);
               end else if (tok.cls == CL_UNDERSCORE && have_ff) begin
                  upend_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end
   end

   assign frac_term = -frac_in;
   assign exp_term  = eneg_in ? -eacc_in : eacc_in;
   assign total     = EXP_OUT_W'(signed'(frac_term)) + EXP_OUT_W'(signed'(exp_term));

   always_comb begin
      out_valid_in = out_valid_ff;
      if (finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         phase_ff  <= PH_START;
         sign_ff   <= 1'b0;
         mant_ff   <= '0;
         frac_ff   <= '0;
         eacc_ff   <= '0;
         eneg_ff   <= 1'b0;
         have_ff   <= 1'b0;
         upend_ff  <= 1'b0;
         failed_ff <= 1'b0;
         wrap_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         sign_ff   <= sign_in;
         mant_ff   <= mant_in;
         frac_ff   <= frac_in;
         eacc_ff   <= eacc_in;
         eneg_ff   <= eneg_in;
         have_ff   <= have_in;
         upend_ff  <= upend_in;
         failed_ff <= failed_in;
         wrap_ff   <= wrap_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (finish) begin
         out_neg_ff  <= sign_in;
         out_mant_ff <= MANT_OUT_W'(mant_in);
         out_exp_ff  <= total;
         out_long_ff <= (phase_in == PH_LONG);
         out_err_ff  <= failed_in || upend_in || !have_in;
         out_wrap_ff <= wrap_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.negative         = out_neg_ff;
   assign rsp_chan.mantissa         = out_mant_ff;
   assign rsp_chan.exponent         = out_exp_ff;
   assign rsp_chan.long_literal     = out_long_ff;
   assign rsp_chan.parse_error      = out_err_ff;
   assign rsp_chan.mantissa_wrapped = out_wrap_ff;

endmodule
`default_nettype wire

// ----- rtl/decimal_float_literal_parser_unit.sv -----
// Decimal literal parser: one character per request, one response per string.
// Throughput: one character per cycle sustained, independent of the response side
// as long as responses are taken; characters without is_last produce no response.
// Path: the response of a final character is valid once it has passed the front
// register, the two-entry queue and the back-end response register.
// Reset: synchronous, active high; clears the parser state, queue and both valids.
`default_nettype none
module decimal_float_literal_parser_unit
   import dflp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dflp_req_if.sink   req_chan,
   dflp_rsp_if.source rsp_chan
);

   token_type front_tok, back_tok;
   logic      front_valid, front_ready;
   logic      back_valid, back_ready;

   dflp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .tok_out   (front_tok),
      .tok_valid (front_valid),
      .tok_ready (front_ready)
   );

   dflp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_tok   (front_tok),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_tok    (back_tok),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   dflp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (back_tok),
      .tok_valid (back_valid),
      .tok_ready (back_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

// ----- tb/decimal_float_literal_parser_unit_tb.sv -----
// Testbench for the decimal literal parser: directed and random strings checked by a scoreboard.
`timescale 1ns / 1ps
module decimal_float_literal_parser_unit_tb;
   import dflp_pkg::*;

   localparam int unsigned IDLE_PCT         = 28;
   localparam int unsigned CHAR_TARGET      = 1850;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned STALL_LIMIT      = 4000;
   localparam int unsigned LONG_FRAC_DIGITS = 24;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam int unsigned DRAIN_CYCLES     = 10;
   localparam logic [63:0] DECIMAL_BASE     = 64'd10;

   typedef struct {
      logic               negative;
      logic [63:0]        mantissa;
      logic signed [16:0] exponent;
      logic               long_literal;
      logic               parse_error;
      logic               wrapped;
   } literal_type;

   class literal_scoreboard;
      phase_type   phase;
      bit          sign_neg;
      bit [63:0]   digits;
      bit [15:0]   frac_count;
      bit [15:0]   exp_value;
      bit          exp_neg;
      bit          have_digit;
      bit          underscore_open;
      bit          failed;
      bit          wrapped;
      literal_type expected_q[$];
      int unsigned checked;
      int unsigned mismatches;
      int unsigned error_count;
      int unsigned wrap_count;
      int unsigned long_count;

      function new();
         clear_parse();
      endfunction

      function void clear_parse();
         phase           = PH_START;
         sign_neg        = 1'b0;
         digits          = '0;
         frac_count      = '0;
         exp_value       = '0;
         exp_neg         = 1'b0;
         have_digit      = 1'b0;
         underscore_open = 1'b0;
         failed          = 1'b0;
         wrapped         = 1'b0;
      endfunction

      function void add_digit(bit [3:0] d);
         bit [63:0] limit;
         limit = {64{1'b1}} >> (64 - MANTISSA_BITS);
         if ((digits & limit) > (limit - 64'(d)) / DECIMAL_BASE)
            wrapped = 1'b1;
         digits     = ((digits & limit) * DECIMAL_BASE + 64'(d)) & limit;
         have_digit = 1'b1;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Advance the parser by one accepted request; queue a response on the last one.
      function void note_char(logic [7:0] code, logic last);
         bit          is_dig, is_sign, is_exp, is_long, is_us, took_sign;
         bit [3:0]    d;
         bit [15:0]   frac_term, exp_term;
         literal_type r;
         is_dig    = code >= CHAR_ZERO && code <= CHAR_NINE;
         d         = is_dig ? 4'(code - CHAR_ZERO) : 4'd0;
         is_sign   = code == CHAR_PLUS || code == CHAR_MINUS;
         is_exp    = code == CHAR_E_UPPER || code == CHAR_E_LOWER;
         is_long   = code == CHAR_L_UPPER || code == CHAR_L_LOWER;
         is_us     = code == CHAR_UNDERSCORE;
         took_sign = 1'b0;
         if (!failed) begin
            if (underscore_open && !is_dig) begin
               failed = 1'b1;
            end else begin
               underscore_open = 1'b0;
               if (phase == PH_START) begin
                  took_sign = is_sign;
                  if (is_sign)
                     sign_neg = code == CHAR_MINUS;
                  phase = PH_INT;
               end
               if (!took_sign) begin
                  case (phase)
                     PH_INT: begin
                        if (is_dig) begin
                           add_digit(d);
                        end else if (is_us && have_digit) begin
                           underscore_open = 1'b1;
                        end else if (is_long) begin
                           phase = PH_LONG;
                        end else if (code == CHAR_DOT) begin
                           phase = PH_FRAC_NEW;
                        end else if (is_exp && have_digit) begin
                           have_digit = 1'b0;
                           phase      = PH_EXP_START;
                        end else begin
                           failed = 1'b1;
                        end
                     end
                     PH_FRAC_NEW, PH_FRAC: begin
                        if (is_dig) begin
                           add_digit(d);
                           frac_count = frac_count + 16'd1;
                           phase      = PH_FRAC;
                        end else if (is_us && phase == PH_FRAC) begin
                           underscore_open = 1'b1;
                        end else if (is_exp && have_digit) begin
                           have_digit = 1'b0;
                           phase      = PH_EXP_START;
                        end else begin
                           failed = 1'b1;
                        end
                     end
                     PH_EXP_START, PH_EXP: begin
                        if (is_dig) begin
                           exp_value  = exp_value * 16'd10 + 16'(d);
                           have_digit = 1'b1;
                           phase      = PH_EXP;
                        end else if (phase == PH_EXP_START && is_sign) begin
                           exp_neg = code == CHAR_MINUS;
                           phase   = PH_EXP;
                        end else if (is_us && have_digit) begin
                           underscore_open = 1'b1;
                        end else begin
                           failed = 1'b1;
                        end
                     end
                     default: failed = 1'b1;
                  endcase
               end
            end
         end
         if (last) begin
            frac_term      = -frac_count;
            exp_term       = exp_neg ? -exp_value : exp_value;
            r.negative     = sign_neg;
            r.mantissa     = digits;
            r.exponent     = 17'($signed(frac_term)) + 17'($signed(exp_term));
            r.long_literal = phase == PH_LONG;
            r.parse_error  = failed || underscore_open || !have_digit;
            r.wrapped      = wrapped;
            expected_q.push_back(r);
            clear_parse();
         end
      endfunction

      function void check_result(literal_type got);
         literal_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response with none pending: mant=%h exp=%0d err=%b",
                        got.mantissa, got.exponent, got.parse_error);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         error_count += want.parse_error;
         wrap_count  += want.wrapped;
         long_count  += want.long_literal;
         if (got.negative !== want.negative || got.mantissa !== want.mantissa ||
             got.exponent !== want.exponent || got.long_literal !== want.long_literal ||
             got.parse_error !== want.parse_error || got.wrapped !== want.wrapped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR: response %0d expected neg=%b mant=%h exp=%0d long=%b err=%b wrap=%b",
                        checked, want.negative, want.mantissa, want.exponent,
                        want.long_literal, want.parse_error, want.wrapped);
               $display("       actual             neg=%b mant=%h exp=%0d long=%b err=%b wrap=%b",
                        got.negative, got.mantissa, got.exponent,
                        got.long_literal, got.parse_error, got.wrapped);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   bit   hold_trigger;
   int unsigned chars_sent;
   int unsigned quiet_cycles;
   literal_scoreboard sb = new();

   dflp_req_if req_bus();
   dflp_rsp_if rsp_bus();

   decimal_float_literal_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Enter and leave at a falling edge; valid stays high into the next call.
   task automatic send_char(input logic [7:0] code, input logic last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.char_code = code;
      req_bus.is_last   = last;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sb.note_char(code, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_word(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   task automatic send_text(input logic [7:0] text[$]);
      foreach (text[i])
         send_char(text[i], i == text.size() - 1);
   endtask

   function automatic logic [7:0] grammar_char();
      case ($urandom_range(9))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_DOT;
         3:       return CHAR_UNDERSCORE;
         4:       return CHAR_E_UPPER;
         5:       return CHAR_E_LOWER;
         6:       return CHAR_L_UPPER;
         7:       return CHAR_L_LOWER;
         default: return CHAR_ZERO + 8'($urandom_range(9));
      endcase
   endfunction

   task automatic append_digits(ref logic [7:0] text[$], input int unsigned count);
      for (int i = 0; i < count; i++) begin
         if (i > 0 && $urandom_range(99) < 12)
            text.push_back(CHAR_UNDERSCORE);
         text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end
   endtask

   // Build one literal: mostly well formed, some mutated, a few pure noise.
   task automatic compose_literal(output logic [7:0] text[$], output bit noisy);
      bit          has_frac, has_exp;
      int unsigned pos;
      text  = {};
      noisy = 1'b0;
      case ($urandom_range(3))
         0:       text.push_back(CHAR_MINUS);
         1:       text.push_back(CHAR_PLUS);
         default: ;
      endcase
      append_digits(text, ($urandom_range(9) == 0) ? $urandom_range(25, 15) : $urandom_range(6));
      has_frac = 1'($urandom_range(1));
      if (has_frac) begin
         text.push_back(CHAR_DOT);
         append_digits(text, $urandom_range(6));
      end
      has_exp = $urandom_range(99) < 35;
      if (has_exp) begin
         text.push_back($urandom_range(1) ? CHAR_E_UPPER : CHAR_E_LOWER);
         case ($urandom_range(2))
            0:       text.push_back(CHAR_MINUS);
            1:       text.push_back(CHAR_PLUS);
            default: ;
         endcase
         append_digits(text, ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1));
      end
      if (!has_frac && !has_exp && $urandom_range(99) < 20)
         text.push_back($urandom_range(1) ? CHAR_L_UPPER : CHAR_L_LOWER);
      if (text.size() == 0)
         text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(99) < 15) begin
         noisy = 1'b1;
         pos   = $urandom_range(text.size() - 1);
         case ($urandom_range(2))
            0:       text[pos] = 8'($urandom_range(255));
            1:       text.insert(pos, grammar_char());
            default: text[pos] = grammar_char();
         endcase
      end else if ($urandom_range(99) < 6) begin
         noisy = 1'b1;
         text  = {};
         repeat ($urandom_range(6, 1))
            text.push_back($urandom_range(1) ? 8'($urandom_range(255)) : grammar_char());
      end
   endtask

   // Responder: random stalls, plus one long hold-off on request.
   initial begin
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = steady || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      literal_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.negative     = rsp_bus.negative;
         got.mantissa     = rsp_bus.mantissa;
         got.exponent     = rsp_bus.exponent;
         got.long_literal = rsp_bus.long_literal;
         got.parse_error  = rsp_bus.parse_error;
         got.wrapped      = rsp_bus.mantissa_wrapped;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR: timeout, nothing moved for %0d cycles, %0d responses pending",
                  quiet_cycles, sb.pending());
         $display("FAIL decimal_float_literal_parser_unit");
         $finish;
      end
   end

   initial begin
      logic [7:0]  text[$];
      bit          noisy;
      bit          paused;
      int unsigned clean_chars;
      int unsigned strings;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = 8'd0;
      req_bus.is_last   = 1'b0;
      steady            = 1'b0;
      hold_trigger      = 1'b0;
      chars_sent        = 0;
      quiet_cycles      = 0;
      paused            = 1'b0;
      clean_chars       = 0;
      strings           = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      send_word("-1_2.5e-3");
      send_word("+9L");
      send_word("E");
      send_word("l0");
      send_word("1_");
      send_word("8.");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_word(".5E1");

      // Wrap the mantissa with one long fraction.
      send_char(CHAR_ZERO, 1'b0);
      send_char(CHAR_DOT, 1'b0);
      repeat (LONG_FRAC_DIGITS) send_char(CHAR_ZERO + 8'd7, 1'b0);
      send_char(CHAR_E_LOWER, 1'b0);
      send_char(CHAR_ZERO + 8'd4, 1'b1);

      hold_trigger = 1'b1;
      while (chars_sent < CHAR_TARGET) begin
         steady = chars_sent >= 700 && chars_sent < 1000;
         if (!paused && chars_sent >= 1300) begin
            paused        = 1'b1;
            req_bus.valid = 1'b0;
            do begin
               @(negedge clock);
            end while (sb.pending() != 0);
         end
         compose_literal(text, noisy);
         send_text(text);
         if (!noisy)
            clean_chars += text.size();
         strings++;
      end
      steady        = 1'b0;
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d characters: directed cases, one %0d-digit fraction, %0d random strings.",
               chars_sent, LONG_FRAC_DIGITS, strings);
      $display("Checked %0d responses (%0d chars well formed): %0d errors, %0d wrapped, %0d long.",
               sb.checked, clean_chars, sb.error_count, sb.wrap_count, sb.long_count);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS decimal_float_literal_parser_unit");
      end else begin
         $display("ERROR: %0d mismatches, %0d responses never arrived",
                  sb.mismatches, sb.pending());
         $display("FAIL decimal_float_literal_parser_unit");
      end
      $finish;
   end

endmodule
